### sv/epwm_pkg.sv
// ----------------------------------------------------------------------------
// epwm_pkg
// Types and constants shared by the expanded-memory page window mapper.
// ----------------------------------------------------------------------------
package epwm_pkg;

  // window geometry
  localparam int unsigned NUM_WINDOWS = 4;
  localparam int unsigned WIN_SHIFT   = 14;
  localparam int unsigned WIN_IDX_W   = $clog2(NUM_WINDOWS);
  localparam int unsigned ADDR_W      = 20;
  localparam int unsigned PAGE_NUM_W  = ADDR_W - WIN_SHIFT;
  localparam int unsigned MEM_BYTES_W = 21;

  // 0xc4000 >> 14: page number of the first window base
  localparam logic [PAGE_NUM_W-1:0] BASE_PAGE = 6'h31;

  // register reset values
  localparam logic [7:0] PAGE_RESET     = 8'h7f;
  localparam logic [7:0] CTRL_RESET_LOW = 8'h80;
  localparam logic [7:0] CTRL_RESET_TOP = 8'h00;

  // operation carried in tuser
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_XLATE = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic {
    CFG_MODEL_THREE = 1'b0,
    CFG_MEM_BYTES   = 1'b1
  } cfg_idx_e;

  // translation result
  typedef struct packed {
    logic                 hit;
    logic [WIN_IDX_W-1:0] window;
    logic [ADDR_W-1:0]    ram_offset;
  } xlate_t;

endpackage

### sv/epwm_xlate.sv
// ----------------------------------------------------------------------------
// epwm_xlate
// Window match and page-to-offset translation of one physical address.
// ----------------------------------------------------------------------------
module epwm_xlate (
  input  logic [epwm_pkg::NUM_WINDOWS-1:0][7:0]   page_regs_i,
  input  logic [2:0]                              base_idx_i,
  input  logic                                    model_three_i,
  input  logic [epwm_pkg::MEM_BYTES_W-1:0]        memory_bytes_i,
  input  logic [epwm_pkg::ADDR_W-1:0]             mem_addr_i,
  output epwm_pkg::xlate_t                        result_o
);
  import epwm_pkg::*;

  logic [PAGE_NUM_W:0]     base_pg;
  logic [PAGE_NUM_W:0]     diff;
  logic                    in_range;
  logic [WIN_IDX_W-1:0]    win;
  logic [7:0]              pg;
  logic [ADDR_W-1:0]       page_off;
  logic                    page_ok;

  // windows are 16 KB, so matching works on the page number alone
  assign base_pg  = {1'b0, BASE_PAGE} + (PAGE_NUM_W+1)'(base_idx_i);
  assign diff     = {1'b0, mem_addr_i[ADDR_W-1:WIN_SHIFT]} - base_pg;
  assign in_range = !diff[PAGE_NUM_W] && (diff[PAGE_NUM_W-1:WIN_IDX_W] == '0);
  assign win      = diff[WIN_IDX_W-1:0];
  assign pg       = page_regs_i[win];

  always_comb begin
    if (model_three_i) begin
      // 7-bit format, pages 0..63
      page_off = {pg[5:0], {WIN_SHIFT{1'b0}}};
      page_ok  = pg[7] && !pg[6];
    end else begin
      // split format: low nibble is the page, bit 6 lands on bit 18
      page_off = {1'b0, pg[6], pg[3:0], {WIN_SHIFT{1'b0}}};
      page_ok  = pg[7];
    end
  end

  always_comb begin
    result_o = '0;
    if (in_range && page_ok && ({1'b0, page_off} < memory_bytes_i)) begin
      result_o.hit        = 1'b1;
      result_o.window     = win;
      result_o.ram_offset = {page_off[ADDR_W-1:WIN_SHIFT], mem_addr_i[WIN_SHIFT-1:0]};
    end
  end

endmodule

### sv/ems_page_window_mapper_unit.sv
// ----------------------------------------------------------------------------
// ems_page_window_mapper_unit
// Expanded-memory mapper: four 16 KB windows, page/control register access
// and address translation on one transaction stream.
// ----------------------------------------------------------------------------
//
// channel   | direction | contents
// ----------+-----------+----------------------------------------------------
// s_axis    | in        | tuser: operation; tdata: io_port, data, mem_addr
// m_axis    | out       | tdata: read_data, hit, window, ram_offset
// cfg       | in        | write-only: model_three (0), memory_bytes (1)
//
// one transaction per cycle sustained while m_axis accepts; each result reaches
// m_axis through the input register, then the result register
// register writes commit when the item leaves the input register, so each
// item sees the effect of every earlier one
// back-pressure stalls both stages together; s_axis_tready_o stays high while
// either stage can move
// reset puts page registers at 0x7f, control registers at 0x80/0x80/0x80/0x00,
// and both configuration registers at zero
// ----------------------------------------------------------------------------
module ems_page_window_mapper_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_index_i,
  input  logic [epwm_pkg::MEM_BYTES_W-1:0]      cfg_data_i,
  // input stream
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [31:0]                           s_axis_tdata_i,  // io_port, data, mem_addr, pad
  input  logic [1:0]                            s_axis_tuser_i,  // operation
  // result stream
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [31:0]                           m_axis_tdata_o   // read_data, hit, window,
                                                                 // ram_offset, pad
);
  import epwm_pkg::*;

  // configuration
  logic                    model_three_q;
  logic [MEM_BYTES_W-1:0]  memory_bytes_q;

  // mapper registers
  logic [NUM_WINDOWS-1:0][7:0] page_q, page_d;
  logic [NUM_WINDOWS-1:0][7:0] ctrl_q, ctrl_d;

  // input stage
  logic                    s1_valid_q;
  logic [1:0]              s1_op_q;
  logic [2:0]              s1_port_q;
  logic [7:0]              s1_data_q;
  logic [ADDR_W-1:0]       s1_addr_q;

  // result stage
  logic                    out_valid_q;
  logic [7:0]              out_rdata_q, out_rdata_d;
  xlate_t                  out_xl_q, out_xl_d;

  logic                    out_ready;
  logic                    s1_fire;
  logic                    in_fire;
  logic [WIN_IDX_W-1:0]    s1_reg;
  logic                    s1_ctl;
  logic [2:0]              base_idx;
  xlate_t                  xl;

  // handshake: result register frees when empty or taken
  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || out_ready;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_fire         = s1_valid_q && out_ready;

  // io_port: bits 2..1 window register, bit 0 control select
  assign s1_reg   = s1_port_q[2:1];
  assign s1_ctl   = s1_port_q[0];

  // bit 7 of control registers 0..2 picks the window base
  assign base_idx = {ctrl_q[2][7], ctrl_q[1][7], ctrl_q[0][7]};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_three_q  <= 1'b0;
      memory_bytes_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODEL_THREE: model_three_q  <= cfg_data_i[0];
        CFG_MEM_BYTES:   memory_bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= s_axis_tuser_i;
      s1_port_q <= s_axis_tdata_i[2:0];
      s1_data_q <= s_axis_tdata_i[10:3];
      s1_addr_q <= s_axis_tdata_i[30:11];
    end
  end

  // translation of the staged address against the current registers
  epwm_xlate u_xlate (
    .page_regs_i    (page_q),
    .base_idx_i     (base_idx),
    .model_three_i  (model_three_q),
    .memory_bytes_i (memory_bytes_q),
    .mem_addr_i     (s1_addr_q),
    .result_o       (xl)
  );

  // operation decode: register update and result fields
  always_comb begin
    page_d      = page_q;
    ctrl_d      = ctrl_q;
    out_rdata_d = '0;
    out_xl_d    = '0;
    case (op_e'(s1_op_q))
      OP_WRITE: begin
        if (s1_ctl) begin
          ctrl_d[s1_reg] = s1_data_q;
        end else begin
          page_d[s1_reg] = s1_data_q;
        end
      end
      OP_READ: begin
        out_rdata_d = s1_ctl ? ctrl_q[s1_reg] : page_q[s1_reg];
      end
      OP_XLATE: begin
        out_xl_d = xl;
      end
      default: ;  // unused operation: no effect, all-zero result
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WINDOWS; i++) begin
        page_q[i] <= PAGE_RESET;
        ctrl_q[i] <= (i == NUM_WINDOWS - 1) ? CTRL_RESET_TOP : CTRL_RESET_LOW;
      end
    end else if (s1_fire) begin
      page_q <= page_d;
      ctrl_q <= ctrl_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_rdata_q <= out_rdata_d;
      out_xl_q    <= out_xl_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_xl_q.ram_offset, out_xl_q.window, out_xl_q.hit,
                            out_rdata_q};

`ifndef ASSERT_OFF
  // a stalled input means both stages are full and the sink is holding
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (s1_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a full pipeline");

  // a hit never carries read data
  a_hit_no_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_xl_q.hit) |-> (out_rdata_q == '0))
    else $error("hit result with nonzero read data");

  // a miss reports window and offset as zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_xl_q.hit) |-> (out_xl_q.window == '0 && out_xl_q.ram_offset == '0))
    else $error("miss result with nonzero window or offset");

  // a committed page write is visible in the next cycle
  a_page_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_op_q == OP_WRITE && !s1_ctl) |=> (page_q[$past(s1_reg)] == $past(s1_data_q)))
    else $error("page register write lost");

  // register state only moves when an item leaves the input stage
  a_regs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> ($stable(page_q) && $stable(ctrl_q)))
    else $error("mapper registers changed without a transaction");
`endif

endmodule
